[src/sca_pkg.sv]
// shared types, constants and the scancode decoder for the scancode-selected alu
// no dependencies
package sca_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned ScanW     = 8;
  localparam int unsigned OpW       = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned OutTdataW = 40;
  localparam int unsigned CntW      = 5;

  localparam logic [CfgIdxW-1:0] CfgOperandA = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOperandB = 1'b1;

  localparam logic [6:0] CodeMask   = 7'h7F;
  localparam logic [6:0] KeyAdd     = 7'h1E;
  localparam logic [6:0] KeyAbsdiff = 7'h1F;
  localparam logic [6:0] KeyMul     = 7'h32;
  localparam logic [6:0] KeyDiv     = 7'h20;
  localparam logic [6:0] KeyMod     = 7'h18;

  typedef enum logic [OpW-1:0] {
    OP_NONE    = 3'd0,
    OP_ADD     = 3'd1,
    OP_ABSDIFF = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_MOD     = 3'd5
  } op_e;

  // request from the item sequencer to the shared unit
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  // release flag in bit 7 is dropped before the compare
  function automatic op_e decode_op(input logic [ScanW-1:0] scan);
    logic [6:0] code;
    op_e        op;
    code = scan[6:0] & CodeMask;
    case (code)
      KeyAdd:     op = OP_ADD;
      KeyAbsdiff: op = OP_ABSDIFF;
      KeyMul:     op = OP_MUL;
      KeyDiv:     op = OP_DIV;
      KeyMod:     op = OP_MOD;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

[src/scancode_selected_alu.sv]
// scancode-selected alu top level: stream handshake, operand registers, stored result
// and output register; depends on sca_pkg and sca_alu
// multiply and divide/remainder iterate 32 times through the shared adder, skipped for a zero divisor
// one item at a time: the next item is taken once the result is in the output register
// reset clears operands, the stored result and all control state; no clearing pass
module scancode_selected_alu (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [sca_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input  logic [sca_pkg::DataW-1:0]        cfg_wdata_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sca_pkg::ScanW-1:0]        s_axis_tdata,   // [7:0] scan_byte
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sca_pkg::OutTdataW-1:0]    m_axis_tdata    // [31:0] result_value,
                                                           // [32] op_done,
                                                           // [35:33] op_code, [39:36] zero
);
  import sca_pkg::*;

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_HOLD
  } tstate_e;

  tstate_e          state_q, state_d;
  op_e              op_q, op_d;
  logic [DataW-1:0] opa_q, opa_d;
  logic [DataW-1:0] opb_q, opb_d;
  logic [DataW-1:0] result_q, result_d;

  // output register
  logic             ovalid_q, ovalid_d;
  logic [DataW-1:0] ovalue_q, ovalue_d;
  op_e              ocode_q, ocode_d;

  logic             in_acc;
  op_e              in_op;
  alu_req_t         alu_req;
  logic             alu_done;
  logic [DataW-1:0] alu_result;
  logic             out_free;

  assign in_op    = decode_op(s_axis_tdata);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;

  // unrecognized codes never wake the unit
  assign alu_req.start = in_acc && (in_op != OP_NONE);
  assign alu_req.op    = in_op;

  sca_alu u_alu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (alu_req),
    .operand_a_i (opa_q),
    .operand_b_i (opb_q),
    .done_o      (alu_done),
    .result_o    (alu_result)
  );

  // operand registers; the user must write them only while idle, as the block does not enforce this
  always_comb begin
    opa_d = opa_q;
    opb_d = opb_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgOperandA: opa_d = cfg_wdata_i;
        CfgOperandB: opb_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // item sequencer: accept, wait on the unit for a recognized code, hand off to the output register
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    result_d = result_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ovalue_d = ovalue_q;
    ocode_d  = ocode_q;
    case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          op_d    = in_op;
          state_d = (in_op == OP_NONE) ? T_HOLD : T_BUSY;
        end
      end
      T_BUSY: begin
        if (alu_done) begin
          result_d = alu_result;
          state_d  = T_HOLD;
        end
      end
      T_HOLD: begin
        // wait here while a previous result is still not taken
        if (out_free) begin
          ovalid_d = 1'b1;
          ovalue_d = result_q;
          ocode_d  = op_q;
          state_d  = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      op_q     <= OP_NONE;
      opa_q    <= '0;
      opb_q    <= '0;
      result_q <= '0;
      ovalid_q <= 1'b0;
      ovalue_q <= '0;
      ocode_q  <= OP_NONE;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      opa_q    <= opa_d;
      opb_q    <= opb_d;
      result_q <= result_d;
      ovalid_q <= ovalid_d;
      ovalue_q <= ovalue_d;
      ocode_q  <= ocode_d;
    end
  end

  assign s_axis_tready = (state_q == T_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(OutTdataW-DataW-1-OpW){1'b0}}, ocode_q,
                          (ocode_q != OP_NONE), ovalue_q};

endmodule

[src/sca_alu.sv]
// iterative arithmetic unit: one shared 33-bit adder/subtractor under a small sequencer
// does add, abs difference, shift-add multiply and restoring signed divide/remainder
// depends on sca_pkg
module sca_alu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sca_pkg::alu_req_t         req_i,
  input  logic [sca_pkg::DataW-1:0] operand_a_i,
  input  logic [sca_pkg::DataW-1:0] operand_b_i,
  output logic                      done_o,
  output logic [sca_pkg::DataW-1:0] result_o
);
  import sca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MAGB,
    S_ITER,
    S_FIX,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [DataW-1:0]  a_q, a_d;
  logic [DataW-1:0]  b_q, b_d;
  logic [DataW-1:0]  acc_q, acc_d;
  logic [DataW-1:0]  x_q, x_d;
  logic [DataW-1:0]  y_q, y_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic [DataW:0]    add_x, add_y;
  logic              add_sub;
  logic [DataW+1:0]  add_sum;
  logic              last_iter;

  assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                   + {{(DataW+1){1'b0}}, add_sub};
  assign last_iter = (cnt_q == {CntW{1'b1}});

  // operand select for the shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      S_PREP: begin
        case (op_q)
          OP_ADD: begin
            add_x = {1'b0, a_q};
            add_y = {1'b0, b_q};
          end
          OP_ABSDIFF: begin
            add_x   = {1'b0, a_q};
            add_y   = {1'b0, b_q};
            add_sub = 1'b1;
          end
          OP_DIV, OP_MOD: begin
            add_y   = {1'b0, a_q};
            add_sub = a_q[DataW-1];
          end
          default: ;
        endcase
      end
      S_MAGB: begin
        add_y   = {1'b0, b_q};
        add_sub = b_q[DataW-1];
      end
      S_ITER: begin
        if (op_q == OP_MUL) begin
          add_x = {1'b0, acc_q};
          add_y = {1'b0, x_q};
        end else begin
          add_x   = {acc_q, x_q[DataW-1]};
          add_y   = {1'b0, y_q};
          add_sub = 1'b1;
        end
      end
      S_FIX: begin
        case (op_q)
          OP_ABSDIFF: begin
            add_y   = {1'b0, acc_q};
            add_sub = acc_q[DataW-1];
          end
          OP_DIV: begin
            add_y   = {1'b0, x_q};
            add_sub = a_q[DataW-1] ^ b_q[DataW-1];
          end
          OP_MOD: begin
            add_y   = {1'b0, acc_q};
            add_sub = a_q[DataW-1];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          a_d     = operand_a_i;
          b_d     = operand_b_i;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cnt_d = '0;
        case (op_q)
          OP_ADD: begin
            acc_d   = add_sum[DataW-1:0];
            state_d = S_DONE;
          end
          OP_ABSDIFF: begin
            acc_d   = add_sum[DataW-1:0];
            state_d = S_FIX;
          end
          OP_MUL: begin
            acc_d   = '0;
            x_d     = a_q;
            y_d     = b_q;
            state_d = S_ITER;
          end
          OP_DIV, OP_MOD: begin
            acc_d = '0;
            if (b_q == '0) begin
              // divide by zero gives zero
              state_d = S_DONE;
            end else begin
              x_d     = add_sum[DataW-1:0];
              state_d = S_MAGB;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MAGB: begin
        y_d     = add_sum[DataW-1:0];
        state_d = S_ITER;
      end
      S_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (op_q == OP_MUL) begin
          if (y_q[0]) begin
            acc_d = add_sum[DataW-1:0];
          end
          x_d = {x_q[DataW-2:0], 1'b0};
          y_d = {1'b0, y_q[DataW-1:1]};
        end else begin
          // carry out set means no borrow: shifted remainder >= divisor
          if (add_sum[DataW+1]) begin
            acc_d = add_sum[DataW-1:0];
          end else begin
            acc_d = {acc_q[DataW-2:0], x_q[DataW-1]};
          end
          x_d = {x_q[DataW-2:0], add_sum[DataW+1]};
        end
        if (last_iter) begin
          state_d = (op_q == OP_MUL) ? S_DONE : S_FIX;
        end
      end
      S_FIX: begin
        acc_d   = add_sum[DataW-1:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign done_o   = (state_q == S_DONE);
  assign result_o = acc_q;

endmodule

[src/sca_checker.sv]
// port-level checker for the scancode-selected alu, bound to the top level
// depends on sca_pkg
module sca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sca_pkg::OutTdataW-1:0] m_axis_tdata
);
  import sca_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // op_done agrees with op_code
  a_done_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[DataW] ==
                       (m_axis_tdata[DataW+OpW:DataW+1] != OP_NONE)))
    else $error("op_done disagrees with op_code");

  // only defined op codes and zero padding
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[DataW+OpW:DataW+1] != 3'd6) &&
                      (m_axis_tdata[DataW+OpW:DataW+1] != 3'd7) &&
                      (m_axis_tdata[OutTdataW-1:DataW+OpW+1] == '0))
    else $error("bad op code or padding");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

endmodule

bind scancode_selected_alu sca_checker u_sca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[bench/testbench.sv]
// self-checking bench for scancode_selected_alu: directed key table, then random
// operand phases with random idling on both stream sides; depends on sca_pkg and the rtl
module testbench;
  import sca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumPhases     = 40;
  localparam int unsigned ItemsPerPhase = 41;
  localparam int unsigned HoldOffCycles = 300;
  // no item or write moves for this long: the block is hung
  localparam int unsigned StallLimit    = 2000;
  // slowest item is a divide or remainder, so this covers any straggler
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned NumKeyCases   = 25;

  // expected result item
  typedef struct packed {
    logic [DataW-1:0] value;
    logic             done;
    op_e              op;
  } alu_result_t;

  // one row of the directed table; known rows carry a hand-typed expectation
  typedef struct {
    logic             load;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [ScanW-1:0] scan;
    logic             known;
    logic [DataW-1:0] val;
    op_e              op;
  } key_case_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_addr_i = CfgOperandA;
  logic [DataW-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ScanW-1:0]     s_axis_tdata = '0;   // [7:0] scan_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // [31:0] result_value, [32] op_done,
                                             // [35:33] op_code, [39:36] zero

  // predictor state: operand registers and the stored result
  logic [DataW-1:0] operand_a_q;
  logic [DataW-1:0] operand_b_q;
  logic [DataW-1:0] stored_result_q;

  alu_result_t pending_results [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          no_gaps;
  bit          hold_off_req;

  key_case_t key_cases [NumKeyCases] = '{
    // straight after reset everything is zero
    '{1'b0, 32'h0, 32'h0, 8'h00, 1'b1, 32'h0, OP_NONE},
    '{1'b0, 32'h0, 32'h0, 8'h9E, 1'b1, 32'h0, OP_ADD},
    // small positives, every operation, release codes act like presses
    '{1'b1, 32'd7, 32'd5, 8'h1E, 1'b1, 32'd12, OP_ADD},
    '{1'b0, 32'h0, 32'h0, 8'h9F, 1'b1, 32'd2, OP_ABSDIFF},
    '{1'b0, 32'h0, 32'h0, 8'h32, 1'b1, 32'd35, OP_MUL},
    '{1'b0, 32'h0, 32'h0, 8'h20, 1'b1, 32'd1, OP_DIV},
    '{1'b0, 32'h0, 32'h0, 8'h18, 1'b1, 32'd2, OP_MOD},
    // unknown codes keep the stored result
    '{1'b0, 32'h0, 32'h0, 8'h7F, 1'b1, 32'd2, OP_NONE},
    '{1'b0, 32'h0, 32'h0, 8'hFF, 1'b1, 32'd2, OP_NONE},
    // sum wraps past the top
    '{1'b1, 32'h7FFF_FFFF, 32'h1, 8'h1E, 1'b1, 32'h8000_0000, OP_ADD},
    '{1'b0, 32'h0, 32'h0, 8'h32, 1'b1, 32'h7FFF_FFFF, OP_MUL},
    // wrapped difference of most negative stays most negative
    '{1'b1, 32'h0, 32'h8000_0000, 8'h1F, 1'b1, 32'h8000_0000, OP_ABSDIFF},
    // most negative over minus one
    '{1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 8'h20, 1'b1, 32'h8000_0000, OP_DIV},
    '{1'b0, 32'h0, 32'h0, 8'h18, 1'b1, 32'h0, OP_MOD},
    // divide by zero
    '{1'b1, 32'd100, 32'h0, 8'h20, 1'b1, 32'h0, OP_DIV},
    '{1'b0, 32'h0, 32'h0, 8'h98, 1'b1, 32'h0, OP_MOD},
    // sign handling of quotient and remainder
    '{1'b1, 32'hFFFF_FFF9, 32'd2, 8'h20, 1'b0, 32'h0, OP_NONE},
    '{1'b0, 32'h0, 32'h0, 8'h18, 1'b0, 32'h0, OP_NONE},
    '{1'b1, 32'd7, 32'hFFFF_FFFE, 8'hA0, 1'b0, 32'h0, OP_NONE},
    '{1'b0, 32'h0, 32'h0, 8'h18, 1'b0, 32'h0, OP_NONE},
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hB2, 1'b1, 32'h1, OP_MUL},
    '{1'b0, 32'h0, 32'h0, 8'h1F, 1'b1, 32'h0, OP_ABSDIFF},
    '{1'b0, 32'h0, 32'h0, 8'h80, 1'b1, 32'h0, OP_NONE},
    '{1'b1, 32'h8000_0000, 32'h8000_0000, 8'h32, 1'b1, 32'h0, OP_MUL},
    '{1'b0, 32'h0, 32'h0, 8'h20, 1'b1, 32'h1, OP_DIV}
  };

  scancode_selected_alu dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor: one key event against the current operands
  function automatic alu_result_t predict_key(input logic [ScanW-1:0] scan);
    logic [6:0]       code;
    logic [DataW-1:0] mag_a;
    logic [DataW-1:0] mag_b;
    logic [DataW-1:0] diff;
    logic [DataW-1:0] quot;
    logic [DataW-1:0] rem;
    op_e              op;
    code  = scan[6:0];
    mag_a = operand_a_q[DataW-1] ? -operand_a_q : operand_a_q;
    mag_b = operand_b_q[DataW-1] ? -operand_b_q : operand_b_q;
    op    = OP_NONE;
    case (code)
      KeyAdd: begin
        op = OP_ADD;
        stored_result_q = operand_a_q + operand_b_q;
      end
      KeyAbsdiff: begin
        op = OP_ABSDIFF;
        diff = operand_a_q - operand_b_q;
        stored_result_q = diff[DataW-1] ? -diff : diff;
      end
      KeyMul: begin
        op = OP_MUL;
        stored_result_q = operand_a_q * operand_b_q;
      end
      KeyDiv: begin
        op = OP_DIV;
        if (operand_b_q == '0) begin
          stored_result_q = '0;
        end else begin
          // quotient truncates toward zero
          quot = mag_a / mag_b;
          stored_result_q = (operand_a_q[DataW-1] ^ operand_b_q[DataW-1]) ? -quot : quot;
        end
      end
      KeyMod: begin
        op = OP_MOD;
        if (operand_b_q == '0) begin
          stored_result_q = '0;
        end else begin
          // remainder follows the dividend sign
          rem = mag_a % mag_b;
          stored_result_q = operand_a_q[DataW-1] ? -rem : rem;
        end
      end
      default: begin
        op = OP_NONE;
      end
    endcase
    return '{stored_result_q, op != OP_NONE, op};
  endfunction

  // operands lean on the edges of the signed range, the rest is random
  function automatic logic [DataW-1:0] draw_operand();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h0;
      1: v = 32'h1;
      2: v = 32'hFFFF_FFFF;
      3: v = 32'h7FFF_FFFF;
      4: v = 32'h8000_0000;
      5: v = 32'($urandom_range(0, 200)) - 32'd100;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // mostly operation keys with a random release flag, some raw noise bytes
  function automatic logic [ScanW-1:0] draw_scan();
    logic [6:0] code;
    if ($urandom_range(0, 9) > 6) begin
      return ScanW'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 4))
      0: code = KeyAdd;
      1: code = KeyAbsdiff;
      2: code = KeyMul;
      3: code = KeyDiv;
      default: code = KeyMod;
    endcase
    return {1'($urandom_range(0, 1)), code};
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] want,
                                 input logic [DataW-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("tb: mismatch in %s at %0t: expected %h got %h", what, $realtime, want, got);
    end
  endtask

  // stop offering, let every pending result drain, then load both operands
  task automatic set_operands(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgOperandA;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    operand_a_q = a;
    cfg_addr_i  <= CfgOperandB;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    operand_b_q = b;
    cfg_we_i    <= 1'b0;
  endtask

  // offer one key item after a random gap and queue its expected result
  task automatic send_scan(input logic [ScanW-1:0] scan, input logic known,
                           input logic [DataW-1:0] val, input op_e op);
    int unsigned gap;
    alu_result_t want;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= scan;
    do @(posedge clk_i); while (!s_axis_tready);
    // predictor always runs so the stored result tracks the block
    want = predict_key(scan);
    if (known) begin
      want = '{val, op != OP_NONE, op};
    end
    pending_results.push_back(want);
  endtask

  // result side: random stalls per item, occasionally a long hold-off
  initial begin
    int unsigned stall;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HoldOffCycles;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 8);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    alu_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, m_axis_tdata[31:0]);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] != want.value) begin
          report_mismatch("result_value", want.value, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[32] != want.done) begin
          report_mismatch("op_done", DataW'(want.done), DataW'(m_axis_tdata[32]));
        end
        if (m_axis_tdata[35:33] != want.op) begin
          report_mismatch("op_code", DataW'(want.op), DataW'(m_axis_tdata[35:33]));
        end
      end
    end
  end

  // count cycles in which nothing moves on any port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin
    operand_a_q     = '0;
    operand_b_q     = '0;
    stored_result_q = '0;
    mismatches      = 0;
    no_gaps         = 1'b0;
    hold_off_req    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (key_cases[i]) begin
      if (key_cases[i].load) begin
        set_operands(key_cases[i].a, key_cases[i].b);
      end
      send_scan(key_cases[i].scan, key_cases[i].known, key_cases[i].val, key_cases[i].op);
    end

    // random phases, each with fresh operands loaded while the block is idle
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      set_operands(draw_operand(), draw_operand());
      // some phases run back to back on both sides
      no_gaps = (phase % 7 == 3);
      // the result side sits still while the sender keeps pushing
      if (phase == 10 || phase == 27) begin
        hold_off_req = 1'b1;
      end
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        send_scan(draw_scan(), 1'b0, '0, OP_NONE);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
src/sca_pkg.sv
src/sca_alu.sv
src/scancode_selected_alu.sv
src/sca_checker.sv
bench/testbench.sv
